// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define BPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/bpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Branch prism mesh package
// Payload types, sequencer codes and the face table.
// ----------------------------------------------------------------------------
package bpm_pkg;

   localparam int UNIT_FRAC = 30;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_FACE   = 1'b1;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
      logic [30:0]        start_half_width;
      logic [30:0]        end_half_width;
   } req_payload_type;

   typedef struct packed {
      logic               item_kind;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic [31:0]        face_index_a;
      logic [31:0]        face_index_b;
      logic [31:0]        face_index_c;
      logic [31:0]        face_index_d;
      logic               degenerate;
      logic               last_of_branch;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_MAG, ST_SHIFT, ST_SQA, ST_SQB, ST_SQC,
      ST_GO, ST_WAIT, ST_O1X, ST_O1Z, ST_O1E, ST_PROD, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_SQRT, OP_DIVA, OP_DIVB
   } op_type;

   typedef enum logic {
      MODE_SQRT, MODE_DIV
   } mode_type;

   typedef struct packed {
      logic     start;
      mode_type mode;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   function automatic logic [2:0] face_offset(input logic [2:0] face, input logic [1:0] n);
      logic [11:0] row;
      case (face)
         3'd0:    row = {3'd0, 3'd1, 3'd2, 3'd3};
         3'd1:    row = {3'd4, 3'd5, 3'd6, 3'd7};
         3'd2:    row = {3'd0, 3'd3, 3'd7, 3'd4};
         3'd3:    row = {3'd1, 3'd2, 3'd6, 3'd5};
         3'd4:    row = {3'd0, 3'd1, 3'd5, 3'd4};
         3'd5:    row = {3'd2, 3'd3, 3'd7, 3'd6};
         default: row = 12'd0;
      endcase
      case (n)
         2'd0:    return row[11:9];
         2'd1:    return row[8:6];
         2'd2:    return row[5:3];
         default: return row[2:0];
      endcase
   endfunction

endpackage

// ----- design/bpm_req_if.sv -----
// ----------------------------------------------------------------------------
// Segment request channel
// Valid/ready channel carrying one branch segment per item.
// ----------------------------------------------------------------------------
interface bpm_req_if;
   import bpm_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/bpm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Mesh record channel
// Valid/ready channel carrying one vertex or face record per item.
// ----------------------------------------------------------------------------
interface bpm_rsp_if;
   import bpm_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/bpm_root_div.sv -----
// ----------------------------------------------------------------------------
// Iterative root and divide unit
// One compare-subtract datapath: 32 steps of integer square root or
// 31 steps of restoring division.
// ----------------------------------------------------------------------------
module bpm_root_div import bpm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  unit_ctl_type ctl,
   input  logic [63:0]  operand,
   input  logic [31:0]  divisor,
   output unit_sts_type sts,
   output logic [31:0]  result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   mode_type    mode_ff, mode_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] acc_ff, acc_in;
   logic [63:0] src_ff, src_in;
   logic [31:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [35:0] shifted, trial;
   logic        ge;

   always_comb begin
      if (mode_ff == MODE_SQRT) begin
         shifted = {rem_ff[33:0], src_ff[63:62]};
         trial   = {2'b00, acc_ff, 2'b01};
      end else begin
         shifted = {rem_ff[34:0], src_ff[63]};
         trial   = {4'b0000, div_ff};
      end
      ge = (shifted >= trial);

      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      src_in  = src_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;

      if (ctl.start && !busy_ff) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         acc_in  = '0;
         div_in  = divisor;
         if (ctl.mode == MODE_SQRT) begin
            rem_in = '0;
            src_in = operand;
            cnt_in = 5'd31;
         end else begin
            rem_in = {5'd0, operand[61:31]};
            src_in = {operand[30:0], 33'd0};
            cnt_in = 5'd30;
         end
      end else if (busy_ff) begin
         rem_in = ge ? (shifted - trial) : shifted;
         acc_in = {acc_ff[30:0], ge};
         src_in = (mode_ff == MODE_SQRT) ? {src_ff[61:0], 2'b00} : {src_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      src_ff  <= src_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = acc_ff;

endmodule

// ----- design/branch_prism_mesh_generator.sv -----
// ----------------------------------------------------------------------------
// Branch prism mesh generator
// Builds a square-section prism around a branch segment and emits eight
// vertex records followed by six face records.
// ----------------------------------------------------------------------------
// One segment is accepted while the block is idle; it then emits 14 records.
// Before the first record the block runs two pair normalizations, each one
// 32-step square root and two 31-step divisions on the shared root/divide
// unit, plus squares, axis products and twelve half-width products on one
// registered 32x32 multiplier. A vertical or zero-length segment skips the
// normalizations. Records then leave one per cycle when the sink is ready.
// A write to the index register restarts face numbering at the
// written value.
module branch_prism_mesh_generator import bpm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bpm_req_if.sink     req,
   bpm_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
`include "assert_macros.svh"

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   req_payload_type    in_ff, in_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic               degen_ff, degen_in;
   logic               pass_ff, pass_in;
   logic [33:0]        na_ff, na_in, nb_ff, nb_in;
   logic [32:0]        dym_ff, dym_in;
   logic [1:0]         sh_ff, sh_in;
   logic [30:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic [63:0]        sum_ff, sum_in;
   logic [31:0]        r_ff, r_in;
   logic [30:0]        qa_ff, qa_in;
   logic [30:0]        uxm_ff, uxm_in, uzm_ff, uzm_in, qm_ff, qm_in, tm_ff, tm_in;
   logic [30:0]        o1x_ff, o1x_in;
   logic [30:0]        om_ff [6];
   logic [30:0]        om_in [6];
   logic               on_ff [6];
   logic               on_in [6];
   logic signed [32:0] pw_ff [12];
   logic signed [32:0] pw_in [12];
   logic               pneg_ff, pneg_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [31:0]        base_ff, base_in;
   logic [31:0]        origin_ff, origin_in;
   rsp_payload_type    out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   logic [63:0]        prod_ff;
   logic [31:0]        mul_a, mul_b;

   unit_ctl_type       u_ctl;
   unit_sts_type       u_sts;
   logic [63:0]        u_operand;
   logic [31:0]        u_result;

   rsp_payload_type    rec;

   bpm_root_div u_root_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (u_ctl),
      .operand (u_operand),
      .divisor (r_ff),
      .sts     (u_sts),
      .result  (u_result)
   );

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sd2147483647)
         return 32'sh7fffffff;
      else if (v < -35'sd2147483648)
         return 32'sh80000000;
      else
         return v[31:0];
   endfunction

   function automatic logic [33:0] mag33(input logic signed [32:0] v);
      logic [32:0] m;
      m = v[32] ? 33'(-v) : v;
      return {1'b0, m};
   endfunction

   // record builder
   always_comb begin
      logic               hi;
      logic               s0neg, s1pos;
      logic signed [34:0] p, a, b, s;
      logic [2:0]         face;
      logic signed [31:0] v [3];
      rec  = '0;
      hi   = cnt_ff[2];
      face = 3'(cnt_ff - 4'd8);
      s0neg = (cnt_ff[1:0] == 2'd0) || (cnt_ff[1:0] == 2'd1);
      s1pos = (cnt_ff[1:0] == 2'd0) || (cnt_ff[1:0] == 2'd3);
      for (int c = 0; c < 3; c++) begin
         case (c)
            0:       p = hi ? 35'(in_ff.end_x) : 35'(in_ff.start_x);
            1:       p = hi ? 35'(in_ff.end_y) : 35'(in_ff.start_y);
            default: p = hi ? 35'(in_ff.end_z) : 35'(in_ff.start_z);
         endcase
         a = hi ? 35'(pw_ff[6 + c]) : 35'(pw_ff[c]);
         b = hi ? 35'(pw_ff[9 + c]) : 35'(pw_ff[3 + c]);
         s = p + (s0neg ? -a : a) + (s1pos ? b : -b);
         v[c] = sat32(s);
      end
      rec.degenerate = degen_ff;
      if (cnt_ff < 4'd8) begin
         rec.item_kind = KIND_VERTEX;
         rec.vert_x    = v[0];
         rec.vert_y    = v[1];
         rec.vert_z    = v[2];
      end else begin
         rec.item_kind      = KIND_FACE;
         rec.face_index_a   = base_ff + 32'(face_offset(face, 2'd0));
         rec.face_index_b   = base_ff + 32'(face_offset(face, 2'd1));
         rec.face_index_c   = base_ff + 32'(face_offset(face, 2'd2));
         rec.face_index_d   = base_ff + 32'(face_offset(face, 2'd3));
         rec.last_of_branch = (cnt_ff == 4'd13);
      end
   end

   always_comb begin
      logic [33:0] ma_w, mb_w;
      logic [2:0]  j6;
      logic [63:0] rnd;
      state_in     = state_ff;
      op_in        = op_ff;
      in_in        = in_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      degen_in     = degen_ff;
      pass_in      = pass_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      dym_in       = dym_ff;
      sh_in        = sh_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      sum_in       = sum_ff;
      r_in         = r_ff;
      qa_in        = qa_ff;
      uxm_in       = uxm_ff;
      uzm_in       = uzm_ff;
      qm_in        = qm_ff;
      tm_in        = tm_ff;
      o1x_in       = o1x_ff;
      om_in        = om_ff;
      on_in        = on_ff;
      pw_in        = pw_ff;
      pneg_in      = pneg_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      origin_in    = origin_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      mul_a        = '0;
      mul_b        = '0;
      u_ctl.start  = 1'b0;
      u_ctl.mode   = MODE_SQRT;
      u_operand    = {1'b0, sum_ff[62:0]};
      req.ready    = (state_ff == ST_IDLE);
      j6           = (cnt_ff < 4'd6) ? cnt_ff[2:0] : 3'(cnt_ff - 4'd6);
      rnd          = prod_ff + 64'(1 << (UNIT_FRAC - 1));
      ma_w         = '0;
      mb_w         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               in_in    = req.payload;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            dx_in    = 33'(in_ff.start_x) - 33'(in_ff.end_x);
            dy_in    = 33'(in_ff.start_y) - 33'(in_ff.end_y);
            dz_in    = 33'(in_ff.start_z) - 33'(in_ff.end_z);
            state_in = ST_MAG;
         end
         ST_MAG: begin
            degen_in = (dx_ff == 33'sd0) && (dz_ff == 33'sd0);
            na_in    = mag33(dx_ff);
            nb_in    = mag33(dz_ff);
            dym_in   = 33'(mag33(dy_ff));
            pass_in  = 1'b0;
            if ((dx_ff == 33'sd0) && (dz_ff == 33'sd0)) begin
               for (int i = 0; i < 6; i++) begin
                  om_in[i] = '0;
                  on_in[i] = 1'b0;
               end
               om_in[0] = 31'(1 << UNIT_FRAC);
               om_in[5] = 31'(1 << UNIT_FRAC);
               cnt_in   = '0;
               state_in = ST_PROD;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if ((na_ff[33] | nb_ff[33]) == 1'b1)
               sh_in = 2'd3;
            else if ((na_ff[32] | nb_ff[32]) == 1'b1)
               sh_in = 2'd2;
            else if ((na_ff[31] | nb_ff[31]) == 1'b1)
               sh_in = 2'd1;
            else
               sh_in = 2'd0;
            ma_w     = na_ff >> sh_in;
            mb_w     = nb_ff >> sh_in;
            ma_in    = ma_w[30:0];
            mb_in    = mb_w[30:0];
            state_in = ST_SQA;
         end
         ST_SQA: begin
            mul_a    = {1'b0, ma_ff};
            mul_b    = {1'b0, ma_ff};
            state_in = ST_SQB;
         end
         ST_SQB: begin
            mul_a    = {1'b0, mb_ff};
            mul_b    = {1'b0, mb_ff};
            sum_in   = prod_ff;
            state_in = ST_SQC;
         end
         ST_SQC: begin
            sum_in   = sum_ff + prod_ff;
            op_in    = OP_SQRT;
            state_in = ST_GO;
         end
         ST_GO: begin
            u_ctl.start = 1'b1;
            case (op_ff)
               OP_SQRT: begin
                  u_ctl.mode = MODE_SQRT;
                  u_operand  = {1'b0, sum_ff[62:0]};
               end
               OP_DIVA: begin
                  u_ctl.mode = MODE_DIV;
                  u_operand  = {3'd0, ma_ff, 30'd0} + {33'd0, r_ff[31:1]};
               end
               default: begin
                  u_ctl.mode = MODE_DIV;
                  u_operand  = {3'd0, mb_ff, 30'd0} + {33'd0, r_ff[31:1]};
               end
            endcase
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (u_sts.done) begin
               case (op_ff)
                  OP_SQRT: begin
                     r_in     = u_result;
                     op_in    = OP_DIVA;
                     state_in = ST_GO;
                  end
                  OP_DIVA: begin
                     qa_in    = u_result[30:0];
                     op_in    = OP_DIVB;
                     state_in = ST_GO;
                  end
                  default: begin
                     if (!pass_ff) begin
                        uxm_in   = qa_ff;
                        uzm_in   = u_result[30:0];
                        na_in    = {2'b00, r_ff} << sh_ff;
                        nb_in    = {1'b0, dym_ff};
                        pass_in  = 1'b1;
                        state_in = ST_SHIFT;
                     end else begin
                        qm_in    = qa_ff;
                        tm_in    = u_result[30:0];
                        state_in = ST_O1X;
                     end
                  end
               endcase
            end
         end
         ST_O1X: begin
            mul_a    = {1'b0, uxm_ff};
            mul_b    = {1'b0, tm_ff};
            state_in = ST_O1Z;
         end
         ST_O1Z: begin
            mul_a    = {1'b0, uzm_ff};
            mul_b    = {1'b0, tm_ff};
            o1x_in   = rnd[UNIT_FRAC +: 31];
            state_in = ST_O1E;
         end
         ST_O1E: begin
            om_in[0] = uzm_ff;
            on_in[0] = !dz_ff[32];
            om_in[1] = '0;
            on_in[1] = 1'b0;
            om_in[2] = uxm_ff;
            on_in[2] = dx_ff[32];
            om_in[3] = o1x_ff;
            on_in[3] = !(dx_ff[32] ^ dy_ff[32]);
            om_in[4] = qm_ff;
            on_in[4] = 1'b0;
            om_in[5] = rnd[UNIT_FRAC +: 31];
            on_in[5] = !(dz_ff[32] ^ dy_ff[32]);
            cnt_in   = '0;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            if (cnt_ff < 4'd12) begin
               mul_a   = {1'b0, om_ff[j6]};
               mul_b   = (cnt_ff < 4'd6) ? {1'b0, in_ff.start_half_width}
                                         : {1'b0, in_ff.end_half_width};
               pneg_in = on_ff[j6];
            end
            if (cnt_ff != 4'd0) begin
               pw_in[cnt_ff - 4'd1] = pneg_ff ? -$signed({1'b0, rnd[UNIT_FRAC +: 32]})
                                              :  $signed({1'b0, rnd[UNIT_FRAC +: 32]});
            end
            if (cnt_ff == 4'd12) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in       = rec;
               out_valid_in = 1'b1;
               cnt_in       = cnt_ff + 4'd1;
               if (cnt_ff == 4'd13) begin
                  base_in  = base_ff + 32'd8;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_wr_en) begin
         origin_in = csr_wr_data;
         base_in   = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         origin_ff    <= 32'd1;
         base_ff      <= 32'd1;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         origin_ff    <= origin_in;
         base_ff      <= base_in;
      end
      op_ff   <= op_in;
      in_ff   <= in_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      degen_ff <= degen_in;
      pass_ff <= pass_in;
      na_ff   <= na_in;
      nb_ff   <= nb_in;
      dym_ff  <= dym_in;
      sh_ff   <= sh_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      sum_ff  <= sum_in;
      r_ff    <= r_in;
      qa_ff   <= qa_in;
      uxm_ff  <= uxm_in;
      uzm_ff  <= uzm_in;
      qm_ff   <= qm_in;
      tm_ff   <= tm_in;
      o1x_ff  <= o1x_in;
      om_ff   <= om_in;
      on_ff   <= on_in;
      pw_ff   <= pw_in;
      pneg_ff <= pneg_in;
      cnt_ff  <= cnt_in;
      out_ff  <= out_in;
      prod_ff <= mul_a * mul_b;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   `BPM_ASSERT(a_busy_after_accept, clock, reset, (req.valid && req.ready) |=> !req.ready, "ready after accept")
   `BPM_ASSERT(a_last_is_face, clock, reset, (rsp.valid && rsp.payload.last_of_branch) |-> (rsp.payload.item_kind == KIND_FACE), "last record not a face")
   `BPM_ASSERT(a_done_in_wait, clock, reset, u_sts.done |-> (state_ff == ST_WAIT), "unit done outside wait")

endmodule

// ----- tb/bpm_mesh_checker.sv -----
// ----------------------------------------------------------------------------
// Branch prism mesh checker
// Watches the segment and record channels and the index register port,
// predicts the fourteen records of every accepted segment and compares each
// accepted record field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bpm_mesh_checker import bpm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bpm_req_if          req,
   bpm_rsp_if          rsp,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          fail_count,
   output int          records_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_payload_type mesh_q[$];
   logic [31:0]     base_index;

   function automatic logic [63:0] mag(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unit_pair(input longint a, input longint b,
                                        output longint ua, output longint ub);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] r;
      logic [63:0] q;
      int          s;
      ma = mag(a);
      mb = mag(b);
      s = 0;
      while ((ma >> s) >= 64'h8000_0000 || (mb >> s) >= 64'h8000_0000) s++;
      ma = ma >> s;
      mb = mb >> s;
      r = int_sqrt(ma * ma + mb * mb);
      q = ((ma << UNIT_FRAC) + r / 2) / r;
      ua = (a < 0) ? -longint'(q) : longint'(q);
      q = ((mb << UNIT_FRAC) + r / 2) / r;
      ub = (b < 0) ? -longint'(q) : longint'(q);
      return longint'(r << s);
   endfunction

   function automatic longint scale_back(input longint u, input logic [63:0] m);
      logic [63:0] p;
      longint      q;
      p = mag(u) * m;
      q = longint'((p + (64'd1 << (UNIT_FRAC - 1))) >> UNIT_FRAC);
      return (u < 0) ? -q : q;
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   task automatic predict_branch(input req_payload_type seg);
      longint          p[2][3];
      longint          w[2];
      longint          o0[3];
      longint          o1[3];
      longint          dx, dy, dz, ux, uz, q, t, h, a, b;
      logic            degen;
      int              s0, s1, corner, e;
      rsp_payload_type rec;
      logic [2:0]      offs[6][4];
      offs = '{'{0, 1, 2, 3}, '{4, 5, 6, 7}, '{0, 3, 7, 4},
               '{1, 2, 6, 5}, '{0, 1, 5, 4}, '{2, 3, 7, 6}};
      p[0][0] = longint'(seg.start_x);
      p[0][1] = longint'(seg.start_y);
      p[0][2] = longint'(seg.start_z);
      p[1][0] = longint'(seg.end_x);
      p[1][1] = longint'(seg.end_y);
      p[1][2] = longint'(seg.end_z);
      w[0] = longint'({33'd0, seg.start_half_width});
      w[1] = longint'({33'd0, seg.end_half_width});
      dx = p[0][0] - p[1][0];
      dy = p[0][1] - p[1][1];
      dz = p[0][2] - p[1][2];
      degen = (dx == 0 && dz == 0);
      if (degen) begin
         o0 = '{64'sd1 << UNIT_FRAC, 0, 0};
         o1 = '{0, 0, 64'sd1 << UNIT_FRAC};
      end else begin
         h = unit_pair(dx, dz, ux, uz);
         void'(unit_pair(h, dy, q, t));
         o0 = '{-uz, 0, ux};
         o1[0] = -scale_back(ux, mag(t)) * ((t < 0) ? -1 : 1);
         o1[1] = q;
         o1[2] = -scale_back(uz, mag(t)) * ((t < 0) ? -1 : 1);
      end
      for (int k = 0; k < 8; k++) begin
         e = k >> 2;
         corner = k & 3;
         s0 = (corner == 0 || corner == 1) ? -1 : 1;
         s1 = (corner == 0 || corner == 3) ? 1 : -1;
         rec = '0;
         rec.item_kind = KIND_VERTEX;
         for (int c = 0; c < 3; c++) begin
            a = scale_back(o0[c], mag(w[e]));
            b = scale_back(o1[c], mag(w[e]));
            case (c)
               0:       rec.vert_x = clamp32(p[e][c] + s0 * a + s1 * b);
               1:       rec.vert_y = clamp32(p[e][c] + s0 * a + s1 * b);
               default: rec.vert_z = clamp32(p[e][c] + s0 * a + s1 * b);
            endcase
         end
         rec.degenerate = degen;
         mesh_q.insert(mesh_q.size(), rec);
      end
      for (int k = 0; k < 6; k++) begin
         rec = '0;
         rec.item_kind = KIND_FACE;
         rec.face_index_a = base_index + offs[k][0];
         rec.face_index_b = base_index + offs[k][1];
         rec.face_index_c = base_index + offs[k][2];
         rec.face_index_d = base_index + offs[k][3];
         rec.degenerate = degen;
         rec.last_of_branch = (k == 5);
         mesh_q.insert(mesh_q.size(), rec);
      end
      base_index = base_index + 32'd8;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      logic            bad;
      if (reset) begin
         base_index = 32'd1;
         mesh_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) base_index = csr_wr_data;
         if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            if (mesh_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected record %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = mesh_q.pop_front();
               bad = (got.item_kind !== want.item_kind) || (got.vert_x !== want.vert_x) ||
                     (got.vert_y !== want.vert_y) || (got.vert_z !== want.vert_z) ||
                     (got.face_index_a !== want.face_index_a) ||
                     (got.face_index_b !== want.face_index_b) ||
                     (got.face_index_c !== want.face_index_c) ||
                     (got.face_index_d !== want.face_index_d) ||
                     (got.degenerate !== want.degenerate) ||
                     (got.last_of_branch !== want.last_of_branch);
               if (bad) begin
                  if (fail_count < 10) begin
                     $display("record mismatch: kind %b/%b xyz %h %h %h / %h %h %h",
                              want.item_kind, got.item_kind, want.vert_x, want.vert_y,
                              want.vert_z, got.vert_x, got.vert_y, got.vert_z);
                     $display("  idx %h %h %h %h / %h %h %h %h  dg %b/%b last %b/%b",
                              want.face_index_a, want.face_index_b, want.face_index_c,
                              want.face_index_d, got.face_index_a, got.face_index_b,
                              got.face_index_c, got.face_index_d, want.degenerate,
                              got.degenerate, want.last_of_branch, got.last_of_branch);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req.valid && req.ready) predict_branch(req.payload);
      end
   end

   assign records_pending = mesh_q.size();

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Branch prism mesh testbench
// Drives directed and random branch segments through several idling phases
// and index origin settings; the checker predicts and compares every record.
// ----------------------------------------------------------------------------
module tb;
   import bpm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_LEN   = 1500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        long_hold = 1'b0;
   int          fail_count;
   int          records_pending;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;

   bpm_req_if req ();
   bpm_rsp_if rsp ();

   branch_prism_mesh_generator u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   bpm_mesh_checker u_chk (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .records_pending(records_pending)
   );

   always #1 clock = ~clock;

   // long receiver stall, counted here once requested
   always @(posedge clock) begin
      if (long_hold && hold_cycles < HOLD_LEN) begin
         rsp.ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(5))
         0:       return $urandom;
         1:       return 32'h7FFF_FFFF - $urandom_range(3);
         2:       return 32'h8000_0000 + $urandom_range(3);
         default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      endcase
   endfunction

   function automatic logic [30:0] pick_width();
      case ($urandom_range(3))
         0:       return 31'($urandom);
         1:       return 31'h7FFF_FFFF - $urandom_range(1);
         default: return 31'($urandom_range(1 << 20));
      endcase
   endfunction

   function automatic req_payload_type random_branch();
      req_payload_type s;
      s.start_x = pick_coord();
      s.start_y = pick_coord();
      s.start_z = pick_coord();
      s.end_x = pick_coord();
      s.end_y = pick_coord();
      s.end_z = pick_coord();
      if ($urandom_range(9) == 0) begin
         s.end_x = s.start_x;
         s.end_z = s.start_z;
      end else if ($urandom_range(9) == 0) begin
         s.end_x = s.start_x;
      end else if ($urandom_range(9) == 0) begin
         s.end_y = s.start_y;
      end
      s.start_half_width = pick_width();
      s.end_half_width = pick_width();
      return s;
   endfunction

   function automatic req_payload_type make_branch(
      input logic [31:0] sx, sy, sz, ex, ey, ez, input logic [30:0] ws, we);
      req_payload_type s;
      s = '{sx, sy, sz, ex, ey, ez, ws, we};
      return s;
   endfunction

   task automatic send_branch(input req_payload_type s);
      int gap;
      req.valid <= 1'b1;
      req.payload <= s;
      do @(posedge clock); while (!req.ready);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (records_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_origin(input logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [31:0] origins[4];
      req.valid = 1'b0;
      req.payload = '0;
      origins = '{32'hFFFF_FFFC, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0};
      origins[3] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_branch(make_branch(0, 0, 0, 0, 0, 0, 0, 0));
      send_branch(make_branch(32'h0001_0000, 32'h0005_0000, 32'h0002_0000,
                              32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                              31'h0001_0000, 31'h0000_8000));
      send_branch(make_branch(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              31'h7FFF_FFFF, 31'h7FFF_FFFF));
      send_branch(make_branch(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              31'h7FFF_FFFF, 31'h0));
      send_branch(make_branch(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 32'h0001_0000,
                              31'h7FFF_FFFF, 31'h7FFF_FFFF));
      send_branch(make_branch(32'h0003_0000, 0, 32'h0004_0000, 0, 0, 0,
                              31'h0001_0000, 31'h0002_0000));
      send_branch(make_branch(0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0,
                              31'h7FFF_FFFF, 31'h1));
      send_branch(make_branch(1, 0, 0, 0, 32'h7FFF_FFFF, 0, 31'h1, 31'h7FFF_FFFF));
      send_branch(make_branch(32'hFFFF_FFFF, 5, 32'hFFFF_FFFF, 0, 5, 0,
                              31'h0000_0001, 31'h0000_0003));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         set_origin(origins[ph]);
         case (ph)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 56; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         for (int i = 0; i < 36; i++) begin
            if (ph == 0 && i == 3) long_hold <= 1'b1;
            send_branch(random_branch());
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
